// ===== hw/rtl/sld_pkg.sv =====
// Shared types and constants for the span light diminishing shader.
// No dependencies; used by sld_shade_unit and span_light_diminish_shade_top.
package sld_pkg;

    // Input command carried in s_tuser
    typedef enum logic [0:0] {
        CMD_SPAN  = 1'b0,
        CMD_PIXEL = 1'b1
    } cmd_t;

    // Configuration register indexes
    localparam logic [0:0] CFG_MODE  = 1'b0;
    localparam logic [0:0] CFG_LEVEL = 1'b1;

    localparam int LEVEL_W  = 8;
    localparam int COLOR_W  = 8;
    localparam int POS_W    = 32;
    localparam int FACTOR_W = 9;   // light factor 8..256

    // 16.16 light constants
    localparam logic [16:0] SHADE_ONE      = 17'd65536;
    localparam logic [33:0] SHADE_BASE     = 34'd131072;
    localparam logic [33:0] SHADE_MAXVIS   = 34'd49152;
    localparam logic [15:0] SHADE_MAXLIGHT = 16'd63488;
    localparam logic [33:0] LEVEL_BIAS     = 34'd12;

    typedef struct packed {
        logic [COLOR_W-1:0] b;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] a;
    } color_t;

    typedef struct packed {
        logic               mode;
        logic [LEVEL_W-1:0] level;
    } shade_cfg_t;

endpackage

// ===== hw/rtl/sld_shade_unit.sv =====
// Combinational light factor and color scaling for one pixel.
// Depends on sld_pkg.
module sld_shade_unit
(
    input  sld_pkg::shade_cfg_t       cfg,
    input  logic [sld_pkg::POS_W-1:0] position,
    input  sld_pkg::color_t           color_in,
    output sld_pkg::color_t           color_out
);

    logic        [33:0]                    level_term;
    logic signed [33:0]                    shade;
    logic signed [33:0]                    pos_s;
    logic signed [33:0]                    m;
    logic signed [33:0]                    diff;
    logic        [15:0]                    c;
    logic        [16:0]                    inv;
    logic        [sld_pkg::FACTOR_W-1:0]   l;
    logic        [16:0]                    prod_r;
    logic        [16:0]                    prod_g;
    logic        [16:0]                    prod_b;

    always_comb
    begin
        level_term = ({{(34-sld_pkg::LEVEL_W){1'b0}}, cfg.level} + sld_pkg::LEVEL_BIAS) << 9;
        shade      = $signed(sld_pkg::SHADE_BASE - level_term);
        pos_s      = $signed({{2{position[31]}}, position});
        m          = (pos_s < $signed(sld_pkg::SHADE_MAXVIS)) ? pos_s
                                                              : $signed(sld_pkg::SHADE_MAXVIS);
        diff       = shade - m;
        if (diff < 34'sd0)
        begin
            c = 16'd0;
        end
        else if (diff > $signed({18'd0, sld_pkg::SHADE_MAXLIGHT}))
        begin
            c = sld_pkg::SHADE_MAXLIGHT;
        end
        else
        begin
            c = diff[15:0];
        end
        // c >= 0 keeps the factor at or below 256
        inv = sld_pkg::SHADE_ONE - {1'b0, c};
        l   = inv[16:8];

        prod_r = {1'b0, color_in.r} * l;
        prod_g = {1'b0, color_in.g} * l;
        prod_b = {1'b0, color_in.b} * l;

        color_out.a = color_in.a;
        if (cfg.mode)
        begin
            color_out.r = prod_r[15:8];
            color_out.g = prod_g[15:8];
            color_out.b = prod_b[15:8];
        end
        else
        begin
            color_out.r = color_in.r;
            color_out.g = color_in.g;
            color_out.b = color_in.b;
        end
    end

endmodule

// ===== hw/rtl/span_light_diminish_shade_top.sv =====
// Span light diminishing shader, top level.
// One item per cycle while the result side does not stall; the position accumulate and the 8x9 color
// multiplies sit between the input and result registers.
// Reset (rst_n, async low): mode passthrough, level 255, position and step 0,
// both stages empty. Depends on sld_pkg and sld_shade_unit.
module span_light_diminish_shade_top
(
    input  logic        clk,
    input  logic        rst_n,

    // Slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: light_start[31:0], light_step[63:32], color_a[71:64],
    //        color_r[79:72], color_g[87:80], color_b[95:88]
    input  logic [95:0] s_tdata,
    // tuser: command[0] (0 span start, 1 pixel)
    input  logic [0:0]  s_tuser,

    // Master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: out_a[7:0], out_r[15:8], out_g[23:16], out_b[31:24]
    output logic [31:0] m_tdata,

    // Configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // Configuration registers
    sld_pkg::shade_cfg_t cfg_reg;

    // Span state
    logic [sld_pkg::POS_W-1:0] position_reg;
    logic [sld_pkg::POS_W-1:0] step_reg;

    // Input stage
    logic                      in_valid_reg;
    sld_pkg::cmd_t             in_cmd_reg;
    logic [sld_pkg::POS_W-1:0] in_start_reg;
    logic [sld_pkg::POS_W-1:0] in_step_reg;
    sld_pkg::color_t           in_color_reg;

    // Result stage
    logic                      out_valid_reg;
    sld_pkg::color_t           out_color_reg;

    sld_pkg::color_t           shaded;
    logic                      advance;
    logic                      is_pixel;

    assign is_pixel = (in_cmd_reg == sld_pkg::CMD_PIXEL);
    // A span start never needs the result register, so it retires freely.
    assign advance  = in_valid_reg && (!is_pixel || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_color_reg;

    sld_shade_unit u_shade
    (
        .cfg       (cfg_reg),
        .position  (position_reg),
        .color_in  (in_color_reg),
        .color_out (shaded)
    );

    // Config writes are to arrive only while idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode  <= 1'b0;
            cfg_reg.level <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sld_pkg::CFG_MODE:  cfg_reg.mode  <= cfg_data[0];
                sld_pkg::CFG_LEVEL: cfg_reg.level <= cfg_data;
                default:            cfg_reg       <= cfg_reg;
            endcase
        end
    end

    // Input register: takes a transfer whenever it is empty or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg   <= sld_pkg::cmd_t'(s_tuser[0]);
            in_start_reg <= s_tdata[31:0];
            in_step_reg  <= s_tdata[63:32];
            in_color_reg <= s_tdata[95:64];
        end
    end

    // Span state: a span start loads, every pixel advances by the step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            step_reg     <= '0;
        end
        else if (advance)
        begin
            if (is_pixel)
            begin
                position_reg <= position_reg + step_reg;
            end
            else
            begin
                position_reg <= in_start_reg;
                step_reg     <= in_step_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_pixel)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_pixel)
        begin
            out_color_reg <= shaded;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench for span_light_diminish_shade_top: 16.16 light diminishing per pixel.
// Self-checking. A scoreboard predicts each shaded color from the input transfers.
// Depends on sld_pkg (cmd_t, color_t) and the top-level RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Light constants, 16.16 fixed point
    localparam longint LIGHT_ONE     = 65536;
    localparam longint LIGHT_BASE    = 131072;
    localparam longint LIGHT_MAXVIS  = 49152;
    localparam longint LIGHT_MAXDIM  = 63488;
    localparam int     PHASES        = 8;
    localparam int     PHASE_ITEMS   = 240;
    localparam int     SETTLE_CYCLES = 4;       // top level has an input and a result register
    localparam int     CYCLE_LIMIT   = 400000;

    // One input transfer as the stimulus side sees it
    typedef struct {
        sld_pkg::cmd_t   cmd;
        logic [31:0]     start;
        logic [31:0]     step;
        sld_pkg::color_t color;
    } span_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    span_item_t      span_items[$];        // waiting to be driven
    span_item_t      on_bus;               // item currently presented on the slave side
    sld_pkg::color_t shaded_due[$];        // predicted shaded colors, oldest first
    int              queued_cnt = 0;
    int              accepted_cnt = 0;
    int              error_cnt = 0;
    int              cycle_cnt = 0;
    int              send_gap = 0;
    int              recv_gap = 0;
    bit              steady = 1'b0;        // no idling on either side when set

    // Predictor state and register copies
    logic [31:0] light_pos = '0;
    logic [31:0] light_inc = '0;
    logic        light_mode = 1'b0;
    logic [7:0]  light_level = 8'd255;

    span_light_diminish_shade_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Scoreboard: apply one accepted transfer to the shading state.
    // Span start loads position and step; a pixel yields a color and advances.
    task automatic shade_transfer(input span_item_t it);
        longint          shade;
        longint          pos;
        longint          dim;
        longint          factor;
        sld_pkg::color_t px;
        if (it.cmd == sld_pkg::CMD_SPAN)
        begin
            light_pos = it.start;
            light_inc = it.step;
        end
        else
        begin
            px = it.color;
            if (light_mode)
            begin
                shade = LIGHT_BASE - (longint'(light_level) + 12) * 512;
                pos = longint'($signed(light_pos));
                if (pos > LIGHT_MAXVIS)
                    pos = LIGHT_MAXVIS;
                dim = shade - pos;              // wide, cannot overflow
                if (dim < 0)
                    dim = 0;
                if (dim > LIGHT_MAXDIM)
                    dim = LIGHT_MAXDIM;
                factor = (LIGHT_ONE - dim) >> 8;
                if (factor > 256)
                    factor = 256;
                px.r = 8'((longint'(it.color.r) * factor) >> 8);
                px.g = 8'((longint'(it.color.g) * factor) >> 8);
                px.b = 8'((longint'(it.color.b) * factor) >> 8);
            end
            shaded_due.push_back(px);
            light_pos = light_pos + light_inc;  // wraps at 32 bits
        end
    endtask

    // Slave-side driver: one transfer per handshake, random idle bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                shade_transfer(on_bus);
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (span_items.size() > 0)
                begin
                    on_bus = span_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {on_bus.color, on_bus.step, on_bus.start};
                    s_tuser <= on_bus.cmd;
                    if (!steady && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 9);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Master-side monitor: check each result transfer, stall in bursts
    always @(posedge clk)
    begin : monitor
        sld_pkg::color_t got;
        sld_pkg::color_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (shaded_due.size() == 0)
                begin
                    $error("unexpected result transfer %h", m_tdata);
                    error_cnt++;
                end
                else
                begin
                    want = shaded_due.pop_front();
                    if (got.a !== want.a)
                    begin
                        $error("out_a expected %0d got %0d", want.a, got.a);
                        error_cnt++;
                    end
                    if (got.r !== want.r)
                    begin
                        $error("out_r expected %0d got %0d", want.r, got.r);
                        error_cnt++;
                    end
                    if (got.g !== want.g)
                    begin
                        $error("out_g expected %0d got %0d", want.g, got.g);
                        error_cnt++;
                    end
                    if (got.b !== want.b)
                    begin
                        $error("out_b expected %0d got %0d", want.b, got.b);
                        error_cnt++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 8);   // start a burst of stall cycles
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic void queue_item(sld_pkg::cmd_t cmd, logic [31:0] start,
                                       logic [31:0] step, sld_pkg::color_t color);
        span_item_t it;
        it.cmd = cmd;
        it.start = start;
        it.step = step;
        it.color = color;
        span_items.push_back(it);
        queued_cnt++;
    endfunction

    // Pixel with random light fields, which the block must ignore
    function automatic void queue_pixel(sld_pkg::color_t color);
        queue_item(sld_pkg::CMD_PIXEL, $urandom, $urandom, color);
    endfunction

    // Span start with random color, also ignored
    function automatic void queue_span(logic [31:0] start, logic [31:0] step);
        queue_item(sld_pkg::CMD_SPAN, start, step, sld_pkg::color_t'($urandom));
    endfunction

    function automatic sld_pkg::color_t pick_color();
        sld_pkg::color_t c;
        c = sld_pkg::color_t'($urandom);
        case ($urandom_range(0, 7))
            0: c = '1;
            1: c = '0;
            2: c.r = 8'hFF;
            default: ;
        endcase
        return c;
    endfunction

    // Mostly well-formed spans whose light passes through the diminishing
    // ramp; now and then a fully random transfer or a wild position/step.
    function automatic void queue_spans(int count);
        int          base;
        int          len;
        logic [31:0] start;
        logic [31:0] step;
        int          stop;
        stop = queued_cnt + count;
        while (queued_cnt < stop)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                queue_item(sld_pkg::cmd_t'($urandom_range(0, 1)), $urandom, $urandom,
                           sld_pkg::color_t'($urandom));
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0: start = $urandom;
                    1: start = {16'h7FFF, 16'($urandom)};
                    default:
                    begin
                        base = int'($urandom_range(0, 300000)) - 200000;
                        start = base;
                    end
                endcase
                if ($urandom_range(0, 5) == 0)
                    step = $urandom;
                else
                begin
                    base = int'($urandom_range(0, 8192)) - 4096;
                    step = base;
                end
                queue_span(start, step);
                len = $urandom_range(1, 20);
                repeat (len)
                    queue_pixel(pick_color());
            end
        end
    endfunction

    // Block until every transfer is in and every result is out, then let the pipeline settle.
    task automatic wait_idle();
        while (accepted_cnt != queued_cnt || shaded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] index, logic [7:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        if (index == sld_pkg::CFG_MODE)
            light_mode = value[0];
        else
            light_level = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Passthrough out of reset, before any span start
        queue_pixel('1);
        queue_pixel('0);
        wait_idle();

        // Diminishing at reset level, position still zero
        write_reg(sld_pkg::CFG_MODE, 8'd1);
        queue_pixel('1);
        // ordinary span in the ramp
        queue_span(-32'sd40000, -32'sd8000);
        queue_pixel('1);
        queue_pixel(sld_pkg::color_t'(32'h80C0_40FF));
        queue_pixel('1);
        // position wraps from most positive to most negative
        queue_span(32'h7FFF_FFFF, 32'h0000_0001);
        queue_pixel('1);
        queue_pixel('1);
        // most negative position, step of half the range
        queue_span(32'h8000_0000, 32'h8000_0000);
        queue_pixel('1);
        queue_pixel('1);
        queue_pixel('1);
        wait_idle();

        // Darkest sector
        write_reg(sld_pkg::CFG_LEVEL, 8'd0);
        queue_span(-32'sd65536, 32'sd32768);
        queue_pixel('1);
        queue_pixel('1);
        wait_idle();

        // Passthrough still advances the position
        write_reg(sld_pkg::CFG_MODE, 8'd0);
        queue_pixel(sld_pkg::color_t'(32'h0102_03FE));
        wait_idle();
        write_reg(sld_pkg::CFG_MODE, 8'd1);
        write_reg(sld_pkg::CFG_LEVEL, 8'd128);
        queue_pixel('1);
        wait_idle();

        // Random phases across register settings; last one without idling
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(sld_pkg::CFG_MODE, 8'd1);
                    write_reg(sld_pkg::CFG_LEVEL, 8'd0);
                end
                1:
                begin
                    write_reg(sld_pkg::CFG_MODE, 8'd1);
                    write_reg(sld_pkg::CFG_LEVEL, 8'd255);
                end
                2:
                begin
                    write_reg(sld_pkg::CFG_MODE, 8'd0);
                    write_reg(sld_pkg::CFG_LEVEL, 8'($urandom));
                end
                default:
                begin
                    write_reg(sld_pkg::CFG_MODE, 8'd1);
                    write_reg(sld_pkg::CFG_LEVEL, 8'($urandom));
                end
            endcase
            if (ph == PHASES - 1)
                steady = 1'b1;
            queue_spans(PHASE_ITEMS);
            wait_idle();
        end

        if (error_cnt == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
